// ===== rtl/core/scc_pkg.sv =====
`default_nettype none
package scc_pkg;

  localparam int unsigned AddrWidth = 64;
  localparam int unsigned ValueWidth = 64;
  localparam int unsigned ModeWidth = 4;
  localparam int unsigned PrecWidth = 5;
  localparam int unsigned SizeWidth = 4;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth = 64;
  localparam int unsigned ExpWidth = 11;
  localparam int unsigned ManWidth = 53;
  localparam int unsigned SumWidth = 57;
  localparam int unsigned LzWidth = 6;
  localparam int unsigned EpsIdxWidth = 5;
  localparam int unsigned EpsIntWidth = 29;

  localparam logic [ModeWidth-1:0] ModeReset = 4'd0;
  localparam logic [PrecWidth-1:0] PrecReset = 5'd0;
  localparam logic [SizeWidth-1:0] SizeReset = 4'd4;
  localparam logic [ValueWidth-1:0] DeltaReset = 64'd0;

  typedef enum logic [ModeWidth-1:0] {
    MODE_CHG      = 4'd0,
    MODE_UNCH     = 4'd1,
    MODE_FCHG     = 4'd2,
    MODE_FUNCH    = 4'd3,
    MODE_ITOL_CHG = 4'd4,
    MODE_ITOL_UNCH = 4'd5,
    MODE_FTOL_CHG = 4'd6,
    MODE_FTOL_UNCH = 4'd7,
    MODE_INC      = 4'd8,
    MODE_DEC      = 4'd9,
    MODE_INC_BY   = 4'd10,
    MODE_DEC_BY   = 4'd11
  } mode_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_MODE  = 2'd0,
    CFG_PREC  = 2'd1,
    CFG_SIZE  = 2'd2,
    CFG_DELTA = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [AddrWidth-1:0]  addr;
    logic [ValueWidth-1:0] cur;
    logic [ValueWidth-1:0] d_cp;
    logic [ValueWidth-1:0] d_pc;
    logic                  gt;
    logic                  lt;
    logic                  eq;
    logic                  feq;
    logic                  nan;
    logic                  inf_any;
    logic                  inf_val;
    logic                  sub;
    logic [ExpWidth-1:0]   exx;
    logic [ManWidth-1:0]   mx;
    logic [ManWidth-1:0]   my;
    logic [LzWidth-1:0]    sh;
  } s1_t;

  typedef struct packed {
    logic [AddrWidth-1:0]  addr;
    logic [ValueWidth-1:0] cur;
    logic                  other_match;
    logic                  is_ftol;
    logic                  ftol_chg;
    logic                  nan;
    logic                  inf_any;
    logic                  inf_val;
    logic [ExpWidth-1:0]   exx;
    logic [SumWidth-1:0]   r;
  } s2_t;

  typedef struct packed {
    s2_t                 base;
    logic [LzWidth-1:0]  k;
    logic                rz;
  } s3_t;

  function automatic logic [EpsIdxWidth-1:0] eps_index(logic [PrecWidth-1:0] p);
    logic signed [PrecWidth-1:0] ps;
    logic [EpsIdxWidth-1:0] idx;
    ps = $signed(p);
    if (ps < -5'sd9) begin
      idx = 5'd0;
    end else if (ps > 5'sd9) begin
      idx = 5'd18;
    end else begin
      idx = p + 5'd9;
    end
    return idx;
  endfunction

  function automatic logic [ValueWidth-1:0] eps_bits(logic [EpsIdxWidth-1:0] idx);
    logic [ValueWidth-1:0] e;
    unique case (idx)
      5'd0:  e = 64'h41BDCD6500000000;
      5'd1:  e = 64'h4187D78400000000;
      5'd2:  e = 64'h415312D000000000;
      5'd3:  e = 64'h411E848000000000;
      5'd4:  e = 64'h40E86A0000000000;
      5'd5:  e = 64'h40B3880000000000;
      5'd6:  e = 64'h407F400000000000;
      5'd7:  e = 64'h4049000000000000;
      5'd8:  e = 64'h4014000000000000;
      5'd9:  e = 64'h3FE0000000000000;
      5'd10: e = 64'h3FA999999999999A;
      5'd11: e = 64'h3F747AE147AE147B;
      5'd12: e = 64'h3F40624DD2F1A9FC;
      5'd13: e = 64'h3F0A36E2EB1C432D;
      5'd14: e = 64'h3ED4F8B588E368F1;
      5'd15: e = 64'h3EA0C6F7A0B5ED8D;
      5'd16: e = 64'h3E6AD7F29ABCAF48;
      5'd17: e = 64'h3E35798EE2308C3A;
      5'd18: e = 64'h3E012E0BE826D695;
      default: e = 64'h3E012E0BE826D695;
    endcase
    return e;
  endfunction

  function automatic logic [EpsIntWidth-1:0] eps_int(logic [EpsIdxWidth-1:0] idx);
    logic [EpsIntWidth-1:0] e;
    unique case (idx)
      5'd0: e = 29'd500000000;
      5'd1: e = 29'd50000000;
      5'd2: e = 29'd5000000;
      5'd3: e = 29'd500000;
      5'd4: e = 29'd50000;
      5'd5: e = 29'd5000;
      5'd6: e = 29'd500;
      5'd7: e = 29'd50;
      5'd8: e = 29'd5;
      default: e = 29'd0;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/snapshot_change_compare.sv =====
// snapshot change compare
// s_axis carries one request per entry: address, current value and snapshot
// value. m_axis carries the address and masked current value of each entry
// that passes the test set by compare_mode; failing entries produce nothing.
// configuration is written through cfg_write/cfg_index/cfg_data while idle;
// the user must keep to that, as the block itself does not enforce it.
// throughput: one request per cycle while m_tready holds high, set by the
// four register stages (unpack and compare, align and add, leading-one
// search, round and test). a stage holds while the stage after it is full
// and stalled, so when m_tready is low the pipeline fills and then s_tready
// falls; nothing is dropped or repeated.
// reset (rst, synchronous) empties the pipeline and sets compare_mode 0,
// tolerance_precision 0, value_bytes 4 and step_delta 0.
`default_nettype none
module snapshot_change_compare
  import scc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // entry_address, current_value, previous_value
  input  wire logic [191:0]             s_tdata,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // match_address, new_snapshot_value
  output logic [127:0]                  m_tdata
);

  logic [ModeWidth-1:0] compare_mode;
  logic [PrecWidth-1:0] tolerance_precision;
  logic [SizeWidth-1:0] value_bytes;
  logic [ValueWidth-1:0] step_delta;
  logic [EpsIdxWidth-1:0] eps_idx;

  logic v1, v2, v3;
  logic r1, r2, r3, r4;
  s1_t st1;
  s2_t st2;
  s3_t st3;

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_mode <= ModeReset;
      tolerance_precision <= PrecReset;
      value_bytes <= SizeReset;
      step_delta <= DeltaReset;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MODE:  compare_mode <= cfg_data[ModeWidth-1:0];
        CFG_PREC:  tolerance_precision <= cfg_data[PrecWidth-1:0];
        CFG_SIZE:  value_bytes <= cfg_data[SizeWidth-1:0];
        CFG_DELTA: step_delta <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eps_idx = eps_index(tolerance_precision);

  assign r4 = !m_tvalid || m_tready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign s_tready = r1;

  scc_unpack u_unpack (
    .clk            (clk),
    .rst            (rst),
    .load           (r1),
    .valid_in       (s_tvalid),
    .value_bytes    (value_bytes),
    .entry_address  (s_tdata[63:0]),
    .current_value  (s_tdata[127:64]),
    .previous_value (s_tdata[191:128]),
    .valid          (v1),
    .stage          (st1)
  );

  scc_align u_align (
    .clk          (clk),
    .rst          (rst),
    .load         (r2),
    .valid_in     (v1),
    .stage_in     (st1),
    .compare_mode (compare_mode),
    .eps_idx      (eps_idx),
    .step_delta   (step_delta),
    .valid        (v2),
    .stage        (st2)
  );

  scc_lzc u_lzc (
    .clk      (clk),
    .rst      (rst),
    .load     (r3),
    .valid_in (v2),
    .stage_in (st2),
    .valid    (v3),
    .stage    (st3)
  );

  scc_round u_round (
    .clk                (clk),
    .rst                (rst),
    .load               (r4),
    .valid_in           (v3),
    .stage_in           (st3),
    .eps_idx            (eps_idx),
    .valid              (m_tvalid),
    .match_address      (m_tdata[63:0]),
    .new_snapshot_value (m_tdata[127:64])
  );

endmodule
`default_nettype wire

// ===== rtl/core/scc_unpack.sv =====
`default_nettype none
module scc_unpack
  import scc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire logic                  valid_in,
  input  wire logic [SizeWidth-1:0]  value_bytes,
  input  wire logic [AddrWidth-1:0]  entry_address,
  input  wire logic [ValueWidth-1:0] current_value,
  input  wire logic [ValueWidth-1:0] previous_value,
  output logic                       valid,
  output s1_t                        stage
);

  typedef struct packed {
    logic                sgn;
    logic [ExpWidth-1:0] ex;
    logic [ManWidth-1:0] m;
    logic                nan;
    logic                inf;
    logic                zero;
  } fp_t;

  function automatic fp_t unpack(logic [ValueWidth-1:0] v, logic single);
    fp_t f;
    if (single) begin
      f.sgn  = v[31];
      f.ex   = ((v[30:23] == 8'd0) ? 11'd1 : {3'd0, v[30:23]}) + 11'd896;
      f.m    = {(v[30:23] != 8'd0), v[22:0], 29'd0};
      f.nan  = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
      f.inf  = (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
      f.zero = (v[30:0] == 31'd0);
    end else begin
      f.sgn  = v[63];
      f.ex   = (v[62:52] == 11'd0) ? 11'd1 : v[62:52];
      f.m    = {(v[62:52] != 11'd0), v[51:0]};
      f.nan  = (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
      f.inf  = (v[62:52] == 11'h7FF) && (v[51:0] == 52'd0);
      f.zero = (v[62:0] == 63'd0);
    end
    return f;
  endfunction

  logic [3:0] n;
  logic [ValueWidth-1:0] mask, cur, prev;
  logic single, a_ge;
  fp_t fa, fb;
  logic [ExpWidth-1:0] d;
  s1_t stage_next;

  always_comb begin
    if (value_bytes == 4'd0) begin
      n = 4'd1;
    end else if (value_bytes > 4'd8) begin
      n = 4'd8;
    end else begin
      n = value_bytes;
    end
    if (n == 4'd8) begin
      mask = '1;
    end else begin
      mask = ~({ValueWidth{1'b1}} << {n[2:0], 3'd0});
    end
    cur = current_value & mask;
    prev = previous_value & mask;
    single = (n == 4'd4);
    fa = unpack(cur, single);
    fb = unpack(prev, single);
    a_ge = {fa.ex, fa.m} >= {fb.ex, fb.m};

    stage_next.addr = entry_address;
    stage_next.cur = cur;
    stage_next.d_cp = cur - prev;
    stage_next.d_pc = prev - cur;
    stage_next.gt = cur > prev;
    stage_next.lt = cur < prev;
    stage_next.eq = cur == prev;
    stage_next.feq = (cur == prev) || (fa.zero && fb.zero);
    stage_next.nan = fa.nan || fb.nan;
    stage_next.inf_any = fa.inf || fb.inf;
    stage_next.inf_val = !(fa.inf && fb.inf && (fa.sgn == fb.sgn));
    stage_next.sub = fa.sgn == fb.sgn;
    stage_next.exx = a_ge ? fa.ex : fb.ex;
    stage_next.mx = a_ge ? fa.m : fb.m;
    stage_next.my = a_ge ? fb.m : fa.m;
    d = a_ge ? (fa.ex - fb.ex) : (fb.ex - fa.ex);
    stage_next.sh = (d > 11'd63) ? 6'd63 : d[LzWidth-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage <= stage_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/scc_align.sv =====
`default_nettype none
module scc_align
  import scc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire logic                   valid_in,
  input  wire s1_t                    stage_in,
  input  wire logic [ModeWidth-1:0]   compare_mode,
  input  wire logic [EpsIdxWidth-1:0] eps_idx,
  input  wire logic [ValueWidth-1:0]  step_delta,
  output logic                        valid,
  output s2_t                         stage
);

  logic [127:0] t;
  logic [55:0] xe, yal;
  logic [ValueWidth-1:0] distance;
  logic dist_gt;
  s2_t stage_next;

  always_comb begin
    t = {stage_in.my, 3'd0, 72'd0} >> stage_in.sh;
    yal = {t[127:73], t[72] | (|t[71:0])};
    xe = {stage_in.mx, 3'd0};
    distance = stage_in.gt ? stage_in.d_cp : stage_in.d_pc;
    dist_gt = distance > {35'd0, eps_int(eps_idx)};

    stage_next.addr = stage_in.addr;
    stage_next.cur = stage_in.cur;
    stage_next.nan = stage_in.nan;
    stage_next.inf_any = stage_in.inf_any;
    stage_next.inf_val = stage_in.inf_val;
    stage_next.exx = stage_in.exx;
    stage_next.r = stage_in.sub ? ({1'b0, xe} - {1'b0, yal}) : ({1'b0, xe} + {1'b0, yal});
    stage_next.is_ftol = 1'b0;
    stage_next.ftol_chg = 1'b0;
    unique case (compare_mode)
      MODE_CHG:       stage_next.other_match = !stage_in.eq;
      MODE_UNCH:      stage_next.other_match = stage_in.eq;
      MODE_FCHG:      stage_next.other_match = !stage_in.nan && !stage_in.feq;
      MODE_FUNCH:     stage_next.other_match = stage_in.nan || stage_in.feq;
      MODE_ITOL_CHG:  stage_next.other_match = dist_gt;
      MODE_ITOL_UNCH: stage_next.other_match = !dist_gt;
      MODE_FTOL_CHG: begin
        stage_next.other_match = 1'b0;
        stage_next.is_ftol = 1'b1;
        stage_next.ftol_chg = 1'b1;
      end
      MODE_FTOL_UNCH: begin
        stage_next.other_match = 1'b0;
        stage_next.is_ftol = 1'b1;
      end
      MODE_INC:       stage_next.other_match = stage_in.gt;
      MODE_DEC:       stage_next.other_match = stage_in.lt;
      MODE_INC_BY:    stage_next.other_match = stage_in.d_cp == step_delta;
      MODE_DEC_BY:    stage_next.other_match = stage_in.d_pc == step_delta;
      default:        stage_next.other_match = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage <= stage_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/scc_lzc.sv =====
`default_nettype none
module scc_lzc
  import scc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load,
  input  wire logic valid_in,
  input  wire s2_t  stage_in,
  output logic      valid,
  output s3_t       stage
);

  logic [LzWidth-1:0] k;

  // position of the leading one
  always_comb begin
    k = '0;
    for (int i = 0; i < SumWidth; i++) begin
      if (stage_in.r[i]) begin
        k = LzWidth'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage.base <= stage_in;
      stage.k <= k;
      stage.rz <= stage_in.r == '0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/scc_round.sv =====
`default_nettype none
module scc_round
  import scc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire logic                   valid_in,
  input  wire s3_t                    stage_in,
  input  wire logic [EpsIdxWidth-1:0] eps_idx,
  output logic                        valid,
  output logic [AddrWidth-1:0]        match_address,
  output logic [ValueWidth-1:0]       new_snapshot_value
);

  logic [SumWidth-1:0] nrm;
  logic [12:0] biased;
  logic normal, up, gt, diff_gt, match;
  logic [64:0] pattern;

  always_comb begin
    nrm = stage_in.base.r << (6'd56 - stage_in.k);
    biased = {7'd0, stage_in.k} + {2'd0, stage_in.base.exx} - 13'd55;
    normal = !stage_in.rz && !biased[12] && (biased != 13'd0);
    up = nrm[3] && ((|nrm[2:0]) || nrm[4]);
    pattern = {1'b0, biased[11:0], nrm[55:4]} + {64'd0, up};
    gt = normal && (pattern > {1'b0, eps_bits(eps_idx)});
    diff_gt = stage_in.base.inf_any ? stage_in.base.inf_val : gt;
    if (!stage_in.base.is_ftol) begin
      match = stage_in.base.other_match;
    end else if (stage_in.base.ftol_chg) begin
      match = !stage_in.base.nan && diff_gt;
    end else begin
      match = stage_in.base.nan || !diff_gt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in && match;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      match_address <= stage_in.base.addr;
      new_snapshot_value <= stage_in.base.cur;
    end
  end

endmodule
`default_nettype wire
